// ===== rtl/double_ended_queue_top_assert.svh =====
// ---------------------------------------------------------------------------
// Deque assertion macros
// Shared assertion forms for the deque checker.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH

// Clocked check, switched off while reset is asserted.
`define DEQ_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("deque check failed");

// Clocked check that also holds during reset.
`define DEQ_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("deque check failed");

`endif

// ===== rtl/deq_pkg.sv =====
// ---------------------------------------------------------------------------
// Deque package
// Sizes, command and status codes, and ring pointer helpers.
// ---------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OCC_W  = 5;
    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Advance a ring pointer by one, wrapping at the last slot.
    function automatic logic [IDX_W-1:0] f_step_up(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + IDX_W'(1);
        end
        return res;
    endfunction

    // Move a ring pointer back by one, wrapping at slot zero.
    function automatic logic [IDX_W-1:0] f_step_down(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == '0) begin
            res = IDX_W'(DEPTH - 1);
        end else begin
            res = idx - IDX_W'(1);
        end
        return res;
    endfunction

endpackage

// ===== rtl/double_ended_queue_top.sv =====
// ---------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed 32-bit words kept in a ring memory.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one command per transfer:
//   push front, push back, pop front or pop back, with the word to push.
//   Output channel (o_out_valid / i_out_stall) returns exactly one result per
//   command: status (ok, empty, full), the front and back words after the
//   command, a flag telling whether those words hold data, and the occupancy.
//   A push, a rejected command, or a pop that empties the queue loads its
//   result into the output register straight from the transfer; such
//   commands sustain one per cycle while the output is not stalled. A pop
//   that leaves words reads the new end word through the registered read
//   port of the ring memory, so its result waits in the read state and the
//   input stalls meanwhile. Front and back words live in cache registers;
//   the memory read data is used only to refill the end word a pop uncovers.
//   When the receiver stalls, the output register holds its result; the next
//   command is still taken and its result parks in the state registers while
//   o_in_stall is raised until the output register frees up.
//   Reset empties the queue and clears both pointers; the ring memory keeps
//   whatever it holds, which is never read before it is written.
// ---------------------------------------------------------------------------
module double_ended_queue_top
    import deq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_command,
    input  logic signed [WORD_W-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_status,
    output logic signed [WORD_W-1:0] o_front_word,
    output logic signed [WORD_W-1:0] o_back_word,
    output logic                     o_words_valid,
    output logic [OCC_W-1:0]         o_occupancy
);

    // Idle takes commands, read waits on the ring memory, send waits on the
    // output register.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SEND = 3'b100
    } t_state;

    // Ring memory: one write port (push), one registered read port (refill).
    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;
    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    logic [IDX_W-1:0]  w_raddr;

    // Queue state
    t_state            r_state,      n_state;
    logic [IDX_W-1:0]  r_front_idx,  n_front_idx;
    logic [IDX_W-1:0]  r_back_idx,   n_back_idx;
    logic [CNT_W-1:0]  r_count,      n_count;
    logic [WORD_W-1:0] r_front_word, n_front_word;
    logic [WORD_W-1:0] r_back_word,  n_back_word;
    t_status           r_status,     n_status;
    logic              r_read_front, n_read_front;

    // Output register
    logic              r_out_valid;
    t_status           r_out_status;
    logic [WORD_W-1:0] r_out_front;
    logic [WORD_W-1:0] r_out_back;
    logic              r_out_words_valid;
    logic [CNT_W-1:0]  r_out_count;

    logic w_accept;
    logic w_need_read;
    logic w_result_ready;
    logic w_out_free;
    logic w_load;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Command decode and state update
    always_comb begin
        n_state      = r_state;
        n_front_idx  = r_front_idx;
        n_back_idx   = r_back_idx;
        n_count      = r_count;
        n_front_word = r_front_word;
        n_back_word  = r_back_word;
        n_status     = r_status;
        n_read_front = r_read_front;
        w_we         = 1'b0;
        w_waddr      = r_front_idx;
        w_raddr      = f_step_up(r_front_idx);
        w_need_read  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status = ST_OK;
                    unique case (t_cmd'(i_command))
                        CMD_PUSH_FRONT: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else if (r_count == '0) begin
                                // First word: both ends land on the front slot.
                                n_back_idx   = r_front_idx;
                                w_we         = 1'b1;
                                w_waddr      = r_front_idx;
                                n_front_word = i_value;
                                n_back_word  = i_value;
                                n_count      = CNT_W'(1);
                            end else begin
                                n_front_idx  = f_step_down(r_front_idx);
                                w_we         = 1'b1;
                                w_waddr      = f_step_down(r_front_idx);
                                n_front_word = i_value;
                                n_count      = r_count + CNT_W'(1);
                            end
                        end
                        CMD_PUSH_BACK: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else if (r_count == '0) begin
                                // First word: both ends land on the back slot.
                                n_front_idx  = r_back_idx;
                                w_we         = 1'b1;
                                w_waddr      = r_back_idx;
                                n_front_word = i_value;
                                n_back_word  = i_value;
                                n_count      = CNT_W'(1);
                            end else begin
                                n_back_idx   = f_step_up(r_back_idx);
                                w_we         = 1'b1;
                                w_waddr      = f_step_up(r_back_idx);
                                n_back_word  = i_value;
                                n_count      = r_count + CNT_W'(1);
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (r_count == CNT_W'(1)) begin
                                // Last word leaves; pointers stay put.
                                n_count = '0;
                            end else begin
                                n_front_idx  = f_step_up(r_front_idx);
                                w_raddr      = f_step_up(r_front_idx);
                                w_need_read  = 1'b1;
                                n_read_front = 1'b1;
                                n_count      = r_count - CNT_W'(1);
                            end
                        end
                        CMD_POP_BACK: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (r_count == CNT_W'(1)) begin
                                n_count = '0;
                            end else begin
                                n_back_idx   = f_step_down(r_back_idx);
                                w_raddr      = f_step_down(r_back_idx);
                                w_need_read  = 1'b1;
                                n_read_front = 1'b0;
                                n_count      = r_count - CNT_W'(1);
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_READ: begin
                // Refill the uncovered end word from the memory read.
                if (r_read_front) begin
                    n_front_word = r_rdata;
                end else begin
                    n_back_word = r_rdata;
                end
            end
            S_SEND: begin
                n_status = r_status;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        w_result_ready = (w_accept && !w_need_read) || (r_state == S_READ) ||
                         (r_state == S_SEND);
        w_load         = w_result_ready && w_out_free;

        if (w_accept && w_need_read) begin
            n_state = S_READ;
        end else if (w_result_ready) begin
            n_state = w_out_free ? S_IDLE : S_SEND;
        end
    end

    // Control and queue state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_front_idx  <= '0;
            r_back_idx   <= '0;
            r_count      <= '0;
            r_status     <= ST_OK;
            r_read_front <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_front_idx  <= n_front_idx;
            r_back_idx   <= n_back_idx;
            r_count      <= n_count;
            r_status     <= n_status;
            r_read_front <= n_read_front;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Cached end words and output payload
    always_ff @(posedge i_clk) begin
        r_front_word <= n_front_word;
        r_back_word  <= n_back_word;
        if (w_load) begin
            r_out_status      <= n_status;
            r_out_count       <= n_count;
            r_out_words_valid <= (n_count != '0);
            // Zero the words on an empty queue.
            r_out_front       <= (n_count != '0) ? n_front_word : '0;
            r_out_back        <= (n_count != '0) ? n_back_word : '0;
        end
    end

    // Ring memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= i_value;
        end
        r_rdata <= r_mem[w_raddr];
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_front_word  = r_out_front;
    assign o_back_word   = r_out_back;
    assign o_words_valid = r_out_words_valid;
    assign o_occupancy   = OCC_W'(r_out_count);

endmodule

// ===== rtl/deq_checker.sv =====
// ---------------------------------------------------------------------------
// Deque port checker
// Watches the deque ports for consistent results over time.
// ---------------------------------------------------------------------------
`include "double_ended_queue_top_assert.svh"

module deq_checker
    import deq_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic [1:0]               o_status,
    input logic signed [WORD_W-1:0] o_front_word,
    input logic signed [WORD_W-1:0] o_back_word,
    input logic                     o_words_valid,
    input logic [OCC_W-1:0]         o_occupancy
);

    // A stalled result holds.
    `DEQ_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) && $stable(o_front_word) && $stable(o_back_word) && $stable(o_occupancy))

    // Valid flag tracks occupancy, and an empty queue shows zero words.
    `DEQ_ASSERT(a_words_flag, o_out_valid |-> (o_words_valid == (o_occupancy != '0)) && (o_words_valid || (o_front_word == '0 && o_back_word == '0)))

    // Occupancy never exceeds the ring size.
    `DEQ_ASSERT(a_occ_bound, o_out_valid |-> o_occupancy <= OCC_W'(DEPTH))

    // Empty status only on an empty queue, full status only on a full one.
    `DEQ_ASSERT(a_status_occ, o_out_valid |-> (o_status != ST_EMPTY || o_occupancy == '0) && (o_status != ST_FULL || o_occupancy == OCC_W'(DEPTH)))

    // No result comes out of reset.
    `DEQ_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_out_valid)

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (.*);
